FILE: rtl/assert_macros.svh
// assertion macros for the queue rtl
// expects clk and rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define CQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on every rising edge outside reset
`define CQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cqsi_pkg.sv
// shared types and codes for the circular queue with sorted insert
// no dependencies
`default_nettype none

package cqsi_pkg;

    localparam int DATA_W = 32;
    localparam int KIND_W = 2;
    localparam int COUNT_OUT_W = 4;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_APPEND  = 2'd0;
    localparam kind_t KIND_ORDERED = 2'd1;
    localparam kind_t KIND_REMOVE  = 2'd2;
    localparam kind_t KIND_SEARCH  = 2'd3;

    typedef struct packed {
        logic insert;
        logic ordered;
        logic remove;
    } cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/cqsi_cell.sv
// one storage cell of the queue chain: holds one entry, shifts left or right
// depends on cqsi_pkg
`default_nettype none

module cqsi_cell (
    input  wire                  clk,
    input  cqsi_pkg::cell_ctl_t  ctl,
    input  cqsi_pkg::data_t      value,
    input  cqsi_pkg::data_t      left_data,
    input  cqsi_pkg::data_t      right_data,
    input  wire                  occupied,
    input  wire                  seen_in,
    output wire                  seen_out,
    output wire                  match,
    output cqsi_pkg::data_t      data
);
    import cqsi_pkg::*;

    data_t data_reg;
    data_t data_next;
    logic  stop;

    // insert point: first free slot, or first entry not less than the word
    assign stop     = !occupied || (ctl.ordered && !(data_reg < value));
    assign seen_out = seen_in || stop;
    assign match    = occupied && (data_reg == value);
    assign data     = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.insert)
        begin
            if (seen_in)
            begin
                data_next = left_data;
            end
            else if (stop)
            begin
                data_next = value;
            end
        end
        else if (ctl.remove)
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

FILE: rtl/circular_queue_with_sorted_insert.sv
// bounded queue of signed words with append, ordered insert, remove and search
// result registered in the cycle after a word is taken; one word per cycle sustained
// unless out_stall holds the result, as the cells shift when each word is taken
// reset clears the occupancy count and the result valid; entries need no clearing pass
// depends on cqsi_pkg, cqsi_cell and assert_macros.svh
`default_nettype none

module circular_queue_with_sorted_insert #(
    parameter int CAPACITY = 15
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_stall,
    input  cqsi_pkg::kind_t      kind,
    input  cqsi_pkg::data_t      value,
    output logic                 out_valid,
    input  wire                  out_stall,
    output logic                 accepted,
    output logic                 found,
    output logic                 head_valid,
    output cqsi_pkg::data_t      head_value,
    output logic [cqsi_pkg::COUNT_OUT_W-1:0] entry_count
);
    import cqsi_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            accepted_reg;
    logic            accepted_next;
    logic            found_reg;
    logic            found_next;

    logic            accept_in;
    logic            full;
    logic            empty;
    logic            ok_ins;
    logic            ok_rem;
    logic            is_search;
    cell_ctl_t       ctl;

    data_t           cell_data [CAPACITY];
    logic [CAPACITY-1:0] occ;
    logic [CAPACITY-1:0] match;
    logic [CAPACITY:0]   seen;
    logic [CW+COUNT_OUT_W-1:0] count_ext;

    assign in_stall  = out_valid_reg && out_stall;
    assign accept_in = in_valid && !in_stall;
    assign full      = (count_reg == CAP_C);
    assign empty     = (count_reg == '0);
    assign is_search = (kind == KIND_SEARCH);
    assign ok_ins    = ((kind == KIND_APPEND) || (kind == KIND_ORDERED)) && !full;
    assign ok_rem    = (kind == KIND_REMOVE) && !empty;

    assign ctl.insert  = accept_in && ok_ins;
    assign ctl.ordered = (kind == KIND_ORDERED);
    assign ctl.remove  = accept_in && ok_rem;

    assign seen[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        data_t left_d;
        data_t right_d;

        assign occ[i] = (CW'(i) < count_reg);

        if (i == 0)
        begin : g_first
            assign left_d = value;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        cqsi_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .value      (value),
            .left_data  (left_d),
            .right_data (right_d),
            .occupied   (occ[i]),
            .seen_in    (seen[i]),
            .seen_out   (seen[i+1]),
            .match      (match[i]),
            .data       (cell_data[i])
        );
    end

    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        accepted_next  = accepted_reg;
        found_next     = found_reg;
        if (ctl.insert)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctl.remove)
        begin
            count_next = count_reg - CW'(1);
        end
        if (accept_in)
        begin
            out_valid_next = 1'b1;
            accepted_next  = ok_ins || ok_rem || is_search;
            found_next     = is_search && (|match);
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        accepted_reg <= accepted_next;
        found_reg    <= found_next;
    end

    // state only moves on an accepted word, so the head and count hold while stalled
    assign count_ext   = {{COUNT_OUT_W{1'b0}}, count_reg};
    assign out_valid   = out_valid_reg;
    assign accepted    = accepted_reg;
    assign found       = found_reg;
    assign head_valid  = !empty;
    assign head_value  = empty ? '0 : cell_data[0];
    assign entry_count = count_ext[COUNT_OUT_W-1:0];

`include "assert_macros.svh"

    `CQ_ASSERT(a_count_bound, (count_reg <= CAP_C), "occupancy above capacity")
    `CQ_ASSERT_IMP(a_ins_count, ctl.insert, (count_reg == $past(count_next)), "count not grown")
    `CQ_ASSERT_IMP(a_ins_head, ctl.insert, head_valid, "queue empty after insert")
    `CQ_ASSERT(a_no_ins_rem, !(ctl.insert && ctl.remove), "insert and remove together")

endmodule

`default_nettype wire
